### hdl/mlfb_pkg.sv
// Package for the monochrome LCD framebuffer draw engine.
// Holds command codes, panel defaults and the request/response types. No dependencies.
package mlfb_pkg;

   localparam int DEF_PANEL_COLUMNS = 128;
   localparam int DEF_PANEL_PAGES   = 8;

   typedef enum logic [3:0] {
      CMD_SET    = 4'd0,
      CMD_CLR    = 4'd1,
      CMD_XOR    = 4'd2,
      CMD_HLINE  = 4'd3,
      CMD_RECT   = 4'd4,
      CMD_CIRCLE = 4'd5,
      CMD_INVERT = 4'd6,
      CMD_CLEAR  = 4'd7,
      CMD_READ   = 4'd8
   } cmd_type;

   typedef struct packed {
      logic [3:0] cmd;
      logic [7:0] x_first;
      logic [7:0] x_last;
      logic [7:0] y_first;
      logic [7:0] y_last;
      logic [7:0] rect_height;
      logic [7:0] rect_width;
      logic [7:0] radius;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out_of_range;
   } rsp_type;

   // Plot modes of one pixel operation.
   typedef enum logic [1:0] {
      PM_SET   = 2'd0,
      PM_CLR   = 2'd1,
      PM_XOR   = 2'd2,
      PM_WRITE = 2'd3
   } pmode_type;

endpackage

### hdl/mlfb_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; the payload type is a parameter.
interface mlfb_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/mlfb_store.sv
// Frame store doing read-modify-write of one pixel operation; depends on mlfb_pkg.
// Operations must be issued one at a time; the block itself does not enforce it.
module mlfb_store
   import mlfb_pkg::*;
#(
   parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
   parameter int PANEL_PAGES   = DEF_PANEL_PAGES,
   localparam int DEPTH = PANEL_COLUMNS * PANEL_PAGES,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            op_valid,
   input  logic [AW-1:0]   op_addr,
   input  pmode_type       op_mode,
   input  logic [7:0]      op_bits,
   output logic            op_busy,
   output logic [7:0]      rd_data
);

   logic [7:0] mem [DEPTH];
   logic       pend_ff;
   logic [AW-1:0] addr_ff;
   pmode_type  mode_ff;
   logic [7:0] bits_ff;
   logic [7:0] new_byte;

   always_ff @(posedge clock) begin
      if (op_valid) begin
         rd_data <= mem[op_addr];
      end
      if (pend_ff) begin
         mem[addr_ff] <= new_byte;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= op_valid;
      addr_ff <= op_addr;
      mode_ff <= op_mode;
      bits_ff <= op_bits;
   end

   always_comb begin
      case (mode_ff)
         PM_SET:   new_byte = rd_data | bits_ff;
         PM_CLR:   new_byte = rd_data & ~bits_ff;
         PM_XOR:   new_byte = rd_data ^ bits_ff;
         PM_WRITE: new_byte = bits_ff;
         default:  new_byte = rd_data;
      endcase
   end

   assign op_busy = pend_ff;

endmodule

### hdl/mono_lcd_framebuffer_draw_engine.sv
// Top level of the monochrome LCD framebuffer draw engine.
// Depends on mlfb_pkg, mlfb_if and mlfb_store.
//
// A request arrives on the req_ channel and always yields exactly one response on
// the rsp_ channel. Each pixel of a shape is a read-modify-write of one frame byte
// in the store, and every pixel position a command steps through, clipped ones
// included, is one ST_GEN step, with ST_WAIT between consecutive steps. A dot
// passes through ST_GEN and ST_DONE and a read through ST_READ, ST_RDONE and
// ST_DONE before its response is registered; the next request can be accepted in
// the cycle the response appears. A line steps through its columns, a circle of
// radius r through eight points for each of its roughly 0.7r + 1 steps, and an
// area of w by h pixels through each of its pixels. Clearing an area steps through
// each byte and once more per page.
// Only one request is in work at a time. After reset the block sweeps the store to
// zero, one byte at a time, and accepts no request until that is done. A stalled
// receiver holds the response register; the block still accepts and finishes one
// more request, keeps its response until the register is free, and accepts nothing
// further meanwhile.
module mono_lcd_framebuffer_draw_engine
   import mlfb_pkg::*;
#(
   parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
   parameter int PANEL_PAGES   = DEF_PANEL_PAGES
) (
   input  logic   clock,
   input  logic   reset,
   mlfb_if.sink   req,
   mlfb_if.source rsp
);

   localparam int DEPTH = PANEL_COLUMNS * PANEL_PAGES;
   localparam int AW = $clog2(DEPTH);
   localparam int ROWS = PANEL_PAGES * 8;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_GEN   = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_RDONE = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   req_type   cur_ff, cur_in;
   logic [8:0] i_ff, i_in;
   logic [8:0] j_ff, j_in;
   logic [3:0] k_ff, k_in;
   logic signed [11:0] t_ff, t_in;
   logic       phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [AW:0] init_ff, init_in;

   logic            op_valid;
   logic [AW-1:0]   op_addr;
   pmode_type       op_mode;
   logic [7:0]      op_bits;
   logic            op_busy;
   logic [7:0]      rd_data;

   mlfb_store #(.PANEL_COLUMNS(PANEL_COLUMNS), .PANEL_PAGES(PANEL_PAGES)) u_store (
      .clock, .op_valid, .op_addr, .op_mode, .op_bits, .op_busy, .rd_data
   );

   // Pixel to issue this step.
   logic       px_en;
   logic [7:0] px_x, px_y;
   pmode_type  px_mode;
   logic       step_last;

   logic [7:0] cx8, cy8;
   assign cx8 = i_ff[7:0];
   assign cy8 = j_ff[7:0];

   function automatic logic [AW-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
      logic [AW+8:0] a;
      a = (AW+9)'(y >> 3) * (AW+9)'(PANEL_COLUMNS) + (AW+9)'(x);
      return a[AW-1:0];
   endfunction

   // Command step generator: at most one pixel per step; flags HLINE/INVERT ends.
   always_comb begin
      px_en     = 1'b0;
      px_x      = cur_ff.x_first;
      px_y      = cur_ff.y_first;
      px_mode   = PM_SET;
      step_last = 1'b1;
      case (cur_ff.cmd)
         CMD_SET, CMD_CLR, CMD_XOR: begin
            px_en   = 1'b1;
            px_mode = pmode_type'(cur_ff.cmd[1:0]);
         end
         CMD_HLINE: begin
            px_en     = (i_ff <= {1'b0, cur_ff.x_last});
            px_x      = cx8;
            step_last = (i_ff >= {1'b0, cur_ff.x_last});
         end
         CMD_RECT: begin
            // k: 0 left side, 1 right side, 2 top, 3 bottom; j counts 0..n-1
            case (k_ff[1:0])
               2'd0: begin
                  px_en = (j_ff < {1'b0, cur_ff.rect_height});
                  px_y  = cur_ff.y_first + cy8;
               end
               2'd1: begin
                  px_en = (j_ff < {1'b0, cur_ff.rect_height});
                  px_x  = cur_ff.x_first + cur_ff.rect_width - 8'd1;
                  px_y  = cur_ff.y_first + cy8;
               end
               2'd2: begin
                  px_en = (j_ff < {1'b0, cur_ff.rect_width});
                  px_x  = cur_ff.x_first + cy8;
               end
               default: begin
                  px_en = (j_ff < {1'b0, cur_ff.rect_width});
                  px_x  = cur_ff.x_first + cy8;
                  px_y  = cur_ff.y_first + cur_ff.rect_height - 8'd1;
               end
            endcase
            step_last = 1'b0;
         end
         CMD_CIRCLE: begin
            px_en = (i_ff <= j_ff) && !j_ff[8];
            case (k_ff[2:0])
               3'd0: begin px_x = cur_ff.x_first + cx8; px_y = cur_ff.y_first + cy8; end
               3'd1: begin px_x = cur_ff.x_first + cx8; px_y = cur_ff.y_first - cy8; end
               3'd2: begin px_x = cur_ff.x_first - cx8; px_y = cur_ff.y_first + cy8; end
               3'd3: begin px_x = cur_ff.x_first - cx8; px_y = cur_ff.y_first - cy8; end
               3'd4: begin px_x = cur_ff.x_first + cy8; px_y = cur_ff.y_first + cx8; end
               3'd5: begin px_x = cur_ff.x_first + cy8; px_y = cur_ff.y_first - cx8; end
               3'd6: begin px_x = cur_ff.x_first - cy8; px_y = cur_ff.y_first + cx8; end
               default: begin px_x = cur_ff.x_first - cy8; px_y = cur_ff.y_first - cx8; end
            endcase
            step_last = 1'b0;
         end
         CMD_INVERT: begin
            px_en     = (i_ff <= {1'b0, cur_ff.x_last}) && (j_ff <= {1'b0, cur_ff.y_last});
            px_x      = cx8;
            px_y      = cy8;
            px_mode   = PM_XOR;
            step_last = (i_ff >= {1'b0, cur_ff.x_last}) && (j_ff >= {1'b0, cur_ff.y_last});
         end
         CMD_CLEAR: begin
            // i column, j page
            px_en     = (i_ff < {1'b0, cur_ff.x_last}) && (j_ff < 9'(cur_ff.y_last >> 3))
                        && (i_ff < 9'(PANEL_COLUMNS)) && (j_ff < 9'(PANEL_PAGES));
            px_x      = cx8;
            px_y      = {cy8[4:0], 3'b000};
            px_mode   = PM_WRITE;
            step_last = 1'b0;
         end
         default: ;
      endcase
   end

   logic px_on_panel;
   assign px_on_panel = (px_mode == PM_WRITE) ||
                        ((px_x < 8'(PANEL_COLUMNS)) && (9'(px_y) < 9'(ROWS)));

   logic gen_end;
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      init_in      = init_ff;
      op_valid     = 1'b0;
      op_addr      = pix_addr(px_x, px_y);
      op_mode      = px_mode;
      op_bits      = (px_mode == PM_WRITE) ? 8'h00 : (8'h01 << px_y[2:0]);
      gen_end      = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            if (!op_busy && !phase_ff) begin
               op_valid = 1'b1;
               op_addr  = init_ff[AW-1:0];
               op_mode  = PM_WRITE;
               op_bits  = 8'h00;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (!phase_ff) ;
               else if (init_ff == (AW+1)'(DEPTH - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  init_in = init_ff + 1'b1;
               end
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               cur_in   = req.payload;
               phase_in = 1'b0;
               k_in     = '0;
               case (req.payload.cmd)
                  CMD_HLINE, CMD_INVERT: begin
                     i_in = {1'b0, req.payload.x_first};
                     j_in = {1'b0, req.payload.y_first};
                  end
                  CMD_CIRCLE: begin
                     i_in = '0;
                     j_in = {1'b0, req.payload.radius};
                     t_in = 12'sd3 - 12'sd2 * $signed({4'b0, req.payload.radius});
                  end
                  CMD_CLEAR: begin
                     i_in = {1'b0, req.payload.x_first};
                     j_in = 9'(req.payload.y_first >> 3);
                  end
                  default: begin
                     i_in = '0;
                     j_in = '0;
                  end
               endcase
               state_in = (req.payload.cmd == CMD_READ) ? ST_READ : ST_GEN;
            end
         end
         ST_GEN: begin
            if (px_en && px_on_panel) begin
               op_valid = 1'b1;
            end
            state_in = ST_WAIT;
            // Advance the iteration.
            case (cur_ff.cmd)
               CMD_HLINE: begin
                  i_in = i_ff + 9'd1;
                  gen_end = step_last || !px_en;
               end
               CMD_RECT: begin
                  if ((k_ff[1] == 1'b0 && j_ff + 9'd1 >= {1'b0, cur_ff.rect_height}) ||
                      (k_ff[1] == 1'b1 && j_ff + 9'd1 >= {1'b0, cur_ff.rect_width}) ||
                      !px_en) begin
                     j_in = '0;
                     k_in = k_ff + 4'd1;
                     gen_end = (k_ff == 4'd3);
                  end else begin
                     j_in = j_ff + 9'd1;
                  end
               end
               CMD_CIRCLE: begin
                  if (!px_en) begin
                     gen_end = 1'b1;
                  end else if (k_ff == 4'd7) begin
                     k_in = '0;
                     if (t_ff < 0) begin
                        t_in = t_ff + 12'sd4 * $signed({3'b0, i_ff}) + 12'sd6;
                     end else begin
                        t_in = t_ff + 12'sd4 * ($signed({3'b0, i_ff}) - $signed({3'b0, j_ff}))
                               + 12'sd10;
                        j_in = j_ff - 9'd1;
                     end
                     i_in = i_ff + 9'd1;
                  end else begin
                     k_in = k_ff + 4'd1;
                  end
               end
               CMD_INVERT: begin
                  if (!px_en) begin
                     gen_end = 1'b1;
                  end else if (j_ff >= {1'b0, cur_ff.y_last}) begin
                     j_in = {1'b0, cur_ff.y_first};
                     i_in = i_ff + 9'd1;
                     gen_end = step_last;
                  end else begin
                     j_in = j_ff + 9'd1;
                  end
               end
               CMD_CLEAR: begin
                  if (!px_en) begin
                     if (i_ff < {1'b0, cur_ff.x_last} && i_ff < 9'(PANEL_COLUMNS) &&
                         j_ff < 9'(cur_ff.y_last >> 3) && j_ff < 9'(PANEL_PAGES)) ;
                     else if (j_ff + 9'd1 < 9'(cur_ff.y_last >> 3) &&
                              j_ff + 9'd1 < 9'(PANEL_PAGES) &&
                              cur_ff.x_first < cur_ff.x_last &&
                              9'(cur_ff.x_first) < 9'(PANEL_COLUMNS)) begin
                        j_in = j_ff + 9'd1;
                        i_in = {1'b0, cur_ff.x_first};
                     end else begin
                        gen_end = 1'b1;
                     end
                  end else begin
                     i_in = i_ff + 9'd1;
                  end
               end
               CMD_SET, CMD_CLR, CMD_XOR: gen_end = 1'b1;
               default: gen_end = 1'b1;
            endcase
            if (gen_end) begin
               state_in = ST_DONE;
            end
         end
         ST_WAIT: begin
            state_in = ST_GEN;
         end
         ST_READ: begin
            if (cur_ff.x_first < 8'(PANEL_COLUMNS) && 9'(cur_ff.y_first) < 9'(PANEL_PAGES)) begin
               op_valid = 1'b1;
               op_addr  = pix_addr(cur_ff.x_first, {cur_ff.y_first[4:0], 3'b000});
               op_mode  = PM_SET;
               op_bits  = 8'h00;
            end
            state_in = ST_RDONE;
         end
         ST_RDONE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // ST_GEN's last write lands in the first cycle here; the response is
            // loaded once the response register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (cur_ff.cmd == CMD_READ) begin
                  if (cur_ff.x_first < 8'(PANEL_COLUMNS) &&
                      9'(cur_ff.y_first) < 9'(PANEL_PAGES)) begin
                     rsp_in = '{read_data: rd_data, out_of_range: 1'b0};
                  end else begin
                     rsp_in = '{read_data: 8'h00, out_of_range: 1'b1};
                  end
               end else begin
                  rsp_in = '{read_data: 8'h00, out_of_range: 1'b0};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         init_ff      <= '0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      t_ff   <= t_in;
      rsp_ff <= rsp_in;
   end

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !req.ready)
      else $error("request accepted during store clearing");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !rsp.valid || $past(rsp.valid))
      else $error("response raised too early");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      op_valid |-> !op_busy || (state_ff == ST_GEN))
      else $error("store operation overlap");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.payload))
      else $error("response changed while stalled");

endmodule

### test/tb_mono_lcd_framebuffer_draw_engine_checker.sv
// Checker for the monochrome LCD framebuffer draw engine: watches both channels,
// keeps its own copy of the frame store and compares every response in order.
// Depends on mlfb_pkg.
module tb_mono_lcd_framebuffer_draw_engine_checker
   import mlfb_pkg::*;
#(
   parameter int COLS  = DEF_PANEL_COLUMNS,
   parameter int PAGES = DEF_PANEL_PAGES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_type rsp_payload,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0] frame_model [COLS*PAGES];
   rsp_type    rsp_expected [$];

   function automatic void put_pixel(int x, int y, pmode_type mode);
      int cx, cy, idx;
      logic [7:0] bit_mask;
      cx = x & 255;
      cy = y & 255;
      if (cx >= COLS || cy >= PAGES * 8) return;
      bit_mask = 8'd1 << (cy & 7);
      idx = (cy >> 3) * COLS + cx;
      case (mode)
         PM_SET:  frame_model[idx] |= bit_mask;
         PM_CLR:  frame_model[idx] &= ~bit_mask;
         default: frame_model[idx] ^= bit_mask;
      endcase
   endfunction

   function automatic void trace_circle(int xc, int yc, int r);
      int px, py, t;
      px = 0;
      py = r;
      t  = 3 - 2 * r;
      while (px <= py) begin
         put_pixel(xc + px, yc + py, PM_SET);
         put_pixel(xc + px, yc - py, PM_SET);
         put_pixel(xc - px, yc + py, PM_SET);
         put_pixel(xc - px, yc - py, PM_SET);
         put_pixel(xc + py, yc + px, PM_SET);
         put_pixel(xc + py, yc - px, PM_SET);
         put_pixel(xc - py, yc + px, PM_SET);
         put_pixel(xc - py, yc - px, PM_SET);
         if (t < 0) begin
            t += 4 * px + 6;
         end else begin
            t += 4 * (px - py) + 10;
            py--;
         end
         px++;
      end
   endfunction

   function automatic rsp_type draw_command(req_type rq);
      rsp_type res;
      int x1, x2, y1, y2, h, w;
      res = '0;
      x1 = rq.x_first;
      x2 = rq.x_last;
      y1 = rq.y_first;
      y2 = rq.y_last;
      h = rq.rect_height;
      w = rq.rect_width;
      case (rq.cmd)
         CMD_SET:  put_pixel(x1, y1, PM_SET);
         CMD_CLR:  put_pixel(x1, y1, PM_CLR);
         CMD_XOR:  put_pixel(x1, y1, PM_XOR);
         CMD_HLINE: for (int i = x1; i <= x2; i++) put_pixel(i, y1, PM_SET);
         CMD_RECT: begin
            for (int j = 0; j < h; j++) begin
               put_pixel(x1, y1 + j, PM_SET);
               put_pixel(x1 + w - 1, y1 + j, PM_SET);
            end
            for (int j = 0; j < w; j++) begin
               put_pixel(x1 + j, y1, PM_SET);
               put_pixel(x1 + j, y1 + h - 1, PM_SET);
            end
         end
         CMD_CIRCLE: trace_circle(x1, y1, rq.radius);
         CMD_INVERT:
            for (int i = x1; i <= x2; i++)
               for (int j = y1; j <= y2; j++) put_pixel(i, j, PM_XOR);
         CMD_CLEAR:
            for (int j = y1 >> 3; j < (y2 >> 3) && j < PAGES; j++)
               for (int i = x1; i < x2 && i < COLS; i++) frame_model[j * COLS + i] = '0;
         CMD_READ:
            if (x1 >= COLS || y1 >= PAGES) res.out_of_range = 1'b1;
            else res.read_data = frame_model[y1 * COLS + x1];
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (reset) begin
         foreach (frame_model[k]) frame_model[k] = '0;
         rsp_expected.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) rsp_expected.push_back(draw_command(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected.size() == 0) begin
               $display("%0t: response with none expected: data %h oor %b", $time,
                        rsp_payload.read_data, rsp_payload.out_of_range);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_expected.pop_front();
               bad = 1'b0;
               if (rsp_payload.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h", $time,
                           want.read_data, rsp_payload.read_data);
                  bad = 1'b1;
               end
               if (rsp_payload.out_of_range !== want.out_of_range) begin
                  $display("%0t: out_of_range expected %b actual %b", $time,
                           want.out_of_range, rsp_payload.out_of_range);
                  bad = 1'b1;
               end
               if (bad) fail_count <= fail_count + 1;
            end
         end
      end
      pending_count = rsp_expected.size();
   end
endmodule

### test/tb_mono_lcd_framebuffer_draw_engine.sv
// Top of the draw engine testbench: clock, reset, directed and random requests,
// random response stalls and verdict. Depends on mlfb_pkg, mlfb_if, engine, checker.
module tb_mono_lcd_framebuffer_draw_engine;
   import mlfb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS = DEF_PANEL_COLUMNS;
   localparam int PAGES = DEF_PANEL_PAGES;
   localparam int RANDOM_REQUESTS = 1030;
   localparam longint CYCLE_LIMIT = 64'd40_000_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   stimulus_done;
   bit   long_hold;
   bit   hold_start;
   longint cycle_count;

   mlfb_if #(.payload_type(req_type)) req_ch (clock);
   mlfb_if #(.payload_type(rsp_type)) rsp_ch (clock);

   mono_lcd_framebuffer_draw_engine i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   tb_mono_lcd_framebuffer_draw_engine_checker #(.COLS(COLS), .PAGES(PAGES)) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_payload(rsp_ch.payload),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
   endfunction

   function automatic logic [7:0] pick_coord(int limit);
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom);
         default: return 8'($urandom_range(0, limit));
      endcase
   endfunction

   function automatic req_type random_request();
      req_type rq;
      rq = '0;
      rq.x_first = pick_coord(COLS - 1);
      rq.y_first = pick_coord(PAGES * 8 - 1);
      rq.x_last = ($urandom_range(0, 5) == 0) ? pick_coord(255)
                                               : 8'(rq.x_first + $urandom_range(0, 12));
      rq.y_last = ($urandom_range(0, 5) == 0) ? pick_coord(255)
                                               : 8'(rq.y_first + $urandom_range(0, 20));
      rq.rect_height = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
      rq.rect_width = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
      rq.radius = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
      case ($urandom_range(0, 19))
         0: rq.cmd = 4'($urandom_range(9, 15));
         1, 2, 3: rq.cmd = CMD_READ;
         4: rq.cmd = CMD_CLEAR;
         5: rq.cmd = CMD_INVERT;
         default: rq.cmd = 4'($urandom_range(0, 5));
      endcase
      if (rq.cmd == CMD_READ) begin
         rq.x_first = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, COLS - 1));
         rq.y_first = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, PAGES - 1));
      end
      return rq;
   endfunction

   function automatic req_type make_request(cmd_type c, int x1, int x2, int y1, int y2,
                                            int h, int w, int r);
      req_type rq;
      rq.cmd = c;
      rq.x_first = 8'(x1);
      rq.x_last = 8'(x2);
      rq.y_first = 8'(y1);
      rq.y_last = 8'(y2);
      rq.rect_height = 8'(h);
      rq.rect_width = 8'(w);
      rq.radius = 8'(r);
      return rq;
   endfunction

   task automatic send_request(req_type rq);
      req_ch.valid <= 1'b1;
      req_ch.payload <= rq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic pause_sender();
      int n;
      n = gap_length();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin
      req_type directed [$];
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      stimulus_done = 1'b0;
      hold_start = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      directed.push_back(make_request(CMD_SET, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_SET, 127, 0, 63, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_SET, 128, 0, 64, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_READ, 127, 0, 7, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_XOR, 127, 0, 63, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_CLR, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_HLINE, 120, 255, 5, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_HLINE, 10, 5, 6, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_RECT, 3, 0, 2, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_RECT, 100, 0, 40, 0, 30, 40, 0));
      directed.push_back(make_request(CMD_CIRCLE, 2, 0, 2, 0, 0, 0, 6));
      directed.push_back(make_request(CMD_CIRCLE, 64, 0, 32, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_INVERT, 250, 255, 60, 255, 0, 0, 0));
      directed.push_back(make_request(CMD_INVERT, 9, 4, 1, 8, 0, 0, 0));
      directed.push_back(make_request(CMD_READ, 120, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_CLEAR, 100, 255, 0, 255, 0, 0, 0));
      directed.push_back(make_request(CMD_CLEAR, 5, 2, 0, 64, 0, 0, 0));
      directed.push_back(make_request(CMD_READ, 128, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_READ, 0, 0, 8, 0, 0, 0, 0));
      directed.push_back(make_request(CMD_READ, 255, 0, 255, 0, 0, 0, 0));
      directed.push_back(make_request(cmd_type'(4'd15), 255, 255, 255, 255, 255, 255, 255));
      directed.push_back(make_request(CMD_READ, 2, 0, 1, 0, 0, 0, 0));
      foreach (directed[k]) begin
         send_request(directed[k]);
         pause_sender();
      end
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 300) hold_start = 1'b1;
         send_request(random_request());
         if (n > 300 && n < 340) continue;
         pause_sender();
      end
      req_ch.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      long_hold = 1'b0;
      @(negedge reset);
      forever begin
         int n;
         if (!long_hold && hold_start) begin
            long_hold = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (3000) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         n = gap_length();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("mono_lcd_framebuffer_draw_engine verification failed");
            $finish;
         end
      end
   end

   initial begin
      wait (stimulus_done);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("mono_lcd_framebuffer_draw_engine verification clean");
      end else begin
         $display("mono_lcd_framebuffer_draw_engine verification failed");
      end
      $finish;
   end
endmodule

### files.f
hdl/mlfb_pkg.sv
hdl/mlfb_if.sv
hdl/mlfb_store.sv
hdl/mono_lcd_framebuffer_draw_engine.sv
test/tb_mono_lcd_framebuffer_draw_engine_checker.sv
test/tb_mono_lcd_framebuffer_draw_engine.sv
